>>> src/dosf_pkg.sv
package dosf_pkg;

    localparam int DEPTH      = 4096;
    localparam int DRAIN_MAX  = 64;

    localparam int SAMPLE_W   = 24;
    localparam int TOTAL_W    = 48;
    localparam int OUT_LVL_W  = 13;
    localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LVL_W      = $clog2(DEPTH + 1);
    localparam int REMAIN_W   = $clog2(DRAIN_MAX + 1);
    localparam int LVL_OUT_MAX = (1 << OUT_LVL_W) - 1;

    // command queue between front and back
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    localparam logic OP_PUSH  = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic [TOTAL_W-1:0]         t_total;
    typedef logic [OUT_LVL_W-1:0]       t_lvl_out;
    typedef logic [LVL_W-1:0]           t_level;
    typedef logic [IDX_W-1:0]           t_index;
    typedef logic [REMAIN_W-1:0]        t_remain;

    typedef struct packed {
        logic    drain;
        t_sample sample;
    } t_cmd;

    // queue head as seen by the back end
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_head;

endpackage

>>> src/dosf_in_if.sv
interface dosf_in_if
    import dosf_pkg::*;
;
    logic    valid;
    logic    ready;
    logic    op;
    t_sample sample;

    modport source (output valid, output op, output sample, input ready);
    modport sink   (input valid, input op, input sample, output ready);
endinterface

>>> src/dosf_out_if.sv
interface dosf_out_if
    import dosf_pkg::*;
;
    logic     valid;
    logic     ready;
    t_sample  out_sample;
    logic     last;
    t_lvl_out fill_level;
    t_total   dropped_total;
    t_total   submitted_total;
    t_lvl_out high_water;

    modport source (
        output valid, output out_sample, output last, output fill_level,
        output dropped_total, output submitted_total, output high_water,
        input  ready
    );
    modport sink (
        input  valid, input out_sample, input last, input fill_level,
        input  dropped_total, input submitted_total, input high_water,
        output ready
    );
endinterface

>>> src/dosf_front.sv
module dosf_front
    import dosf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    dosf_in_if.sink    i_in,
    output t_cmd_head  o_head,
    input  logic       i_pop
);

    t_cmd            r_q [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;
    logic            push;
    logic            pop;
    t_cmd            cmd_in;

    assign i_in.ready = (r_count != QCNT_W'(QDEPTH));
    assign push       = i_in.valid && i_in.ready;
    assign pop        = i_pop && (r_count != '0);

    // classify: drain ticks carry no sample
    always_comb begin
        cmd_in.drain  = (i_in.op == OP_DRAIN);
        cmd_in.sample = (i_in.op == OP_DRAIN) ? '0 : i_in.sample;
    end

    always_comb begin
        n_wr_ptr = push ? QPTR_W'(r_wr_ptr + 1'b1) : r_wr_ptr;
        n_rd_ptr = pop  ? QPTR_W'(r_rd_ptr + 1'b1) : r_rd_ptr;
        n_count  = r_count;
        if (push && !pop) begin
            n_count = QCNT_W'(r_count + 1'b1);
        end else if (pop && !push) begin
            n_count = QCNT_W'(r_count - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= cmd_in;
        end
    end

    assign o_head.valid = (r_count != '0);
    assign o_head.cmd   = r_q[r_rd_ptr];

endmodule

>>> src/dosf_back.sv
module dosf_back
    import dosf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd_head  i_head,
    output logic       o_pop,
    dosf_out_if.source o_out
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    localparam t_total CNT_MAX = '1;
    localparam int     SUM_W   = LVL_W + 1;

    t_state   r_state, n_state;
    t_index   r_head, n_head;
    t_level   r_level, n_level;
    t_total   r_dropped, n_dropped;
    t_total   r_submitted, n_submitted;
    t_level   r_peak, n_peak;
    t_remain  r_remain, n_remain;

    t_sample  mem [DEPTH];
    logic     mem_we;
    logic     mem_re;
    t_index   wr_addr;
    t_index   head_inc;
    logic [SUM_W-1:0] wr_sum;

    t_sample  r_o_sample;
    logic     r_o_last;
    t_lvl_out r_o_fill;
    t_total   r_o_dropped;
    t_total   r_o_submitted;
    t_lvl_out r_o_high;

    function automatic t_lvl_out lvl_out(input t_level v);
        if (LVL_W > OUT_LVL_W && v > LVL_W'(LVL_OUT_MAX)) begin
            lvl_out = t_lvl_out'(LVL_OUT_MAX);
        end else begin
            lvl_out = t_lvl_out'(v);
        end
    endfunction

    function automatic t_total sat_inc(input t_total v);
        sat_inc = (v == CNT_MAX) ? CNT_MAX : t_total'(v + 1'b1);
    endfunction

    assign head_inc = (r_head == IDX_W'(DEPTH - 1)) ? '0 : IDX_W'(r_head + 1'b1);

    // tail slot = head + level; when full this lands on the slot being dropped
    always_comb begin
        wr_sum = SUM_W'(r_head) + SUM_W'(r_level);
        if (wr_sum >= SUM_W'(DEPTH)) begin
            wr_sum = SUM_W'(wr_sum - SUM_W'(DEPTH));
        end
        wr_addr = IDX_W'(wr_sum);
    end

    assign o_pop = (r_state == S_IDLE) && i_head.valid;

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_level     = r_level;
        n_dropped   = r_dropped;
        n_submitted = r_submitted;
        n_peak      = r_peak;
        n_remain    = r_remain;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_head.valid) begin
                    if (!i_head.cmd.drain) begin
                        mem_we      = 1'b1;
                        n_submitted = sat_inc(r_submitted);
                        if (r_level == LVL_W'(DEPTH)) begin
                            n_head    = head_inc;
                            n_dropped = sat_inc(r_dropped);
                        end else begin
                            n_level = LVL_W'(r_level + 1'b1);
                        end
                        if (n_level > r_peak) begin
                            n_peak = n_level;
                        end
                    end else if (r_level != '0) begin
                        if (r_level < LVL_W'(DRAIN_MAX)) begin
                            n_remain = REMAIN_W'(r_level);
                        end else begin
                            n_remain = REMAIN_W'(DRAIN_MAX);
                        end
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                mem_re   = 1'b1;
                n_head   = head_inc;
                n_level  = LVL_W'(r_level - 1'b1);
                n_remain = REMAIN_W'(r_remain - 1'b1);
                n_state  = S_EMIT;
            end
            S_EMIT: begin
                if (o_out.ready) begin
                    n_state = (r_remain == '0) ? S_IDLE : S_READ;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_level     <= '0;
            r_dropped   <= '0;
            r_submitted <= '0;
            r_peak      <= '0;
            r_remain    <= '0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_level     <= n_level;
            r_dropped   <= n_dropped;
            r_submitted <= n_submitted;
            r_peak      <= n_peak;
            r_remain    <= n_remain;
        end
    end

    // sample store, registered read straight into the output register
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[wr_addr] <= i_head.cmd.sample;
        end
        if (mem_re) begin
            r_o_sample <= mem[r_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_READ) begin
            r_o_last      <= (r_remain == REMAIN_W'(1));
            r_o_fill      <= lvl_out(LVL_W'(r_level - 1'b1));
            r_o_dropped   <= r_dropped;
            r_o_submitted <= r_submitted;
            r_o_high      <= lvl_out(r_peak);
        end
    end

    assign o_out.valid           = (r_state == S_EMIT);
    assign o_out.out_sample      = r_o_sample;
    assign o_out.last            = r_o_last;
    assign o_out.fill_level      = r_o_fill;
    assign o_out.dropped_total   = r_o_dropped;
    assign o_out.submitted_total = r_o_submitted;
    assign o_out.high_water      = r_o_high;

endmodule

>>> src/drop_oldest_sample_fifo.sv
// Channel   Dir  Payload                                        Transaction
// i_in      in   op, sample                                     valid & ready
// o_out     out  out_sample, last, fill_level, dropped_total,   valid & ready
//                submitted_total, high_water
//
// A push is taken by the back end straight from idle; a drain tick is
// dispatched from idle, then pops up to 64 samples, each by a store read into
// the output register, then an emit state that holds while o_out.ready is low.
// The store has a single port, so read and write share it one access a cycle.
// Reset (i_rst_n low, synchronous) clears pointers, level, counters and the
// command queue; the sample store is not cleared and needs no clearing pass.
// A 4-entry command queue takes up to four transactions while a result waits
// on o_out; i_in.ready drops once it is full.
module drop_oldest_sample_fifo
    import dosf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    dosf_in_if.sink    i_in,
    dosf_out_if.source o_out
);

    // front end: accepts and classifies transactions into the command queue
    t_cmd_head q_head;
    logic      q_pop;

    dosf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_head  (q_head),
        .i_pop   (q_pop)
    );

    // back end: owns the sample store, level, head pointer and counters,
    // and drains bursts one result transaction at a time
    dosf_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (q_head),
        .o_pop   (q_pop),
        .o_out   (o_out)
    );

endmodule

>>> sim/tb.sv
module tb;
    import dosf_pkg::*;

    localparam int STALL_LIMIT   = 2000;   // cycles with no transaction on either side
    localparam int RANDOM_ITEMS  = 230;
    localparam int BURST_EXTRA   = 6;      // pushes beyond one full drain burst
    localparam int SETTLE_CYCLES = 64;

    // one popped sample as the output channel presents it
    typedef struct packed {
        t_sample  smp;
        logic     last;
        t_lvl_out fill;
        t_total   dropped;
        t_total   submitted;
        t_lvl_out peak;
    } t_pop_rec;

    // Tracks the live window of the queue and the owed pops per drain tick.
    class fifo_scoreboard;
        t_sample  live_q[$];
        t_pop_rec owed_q[$];
        t_total   dropped_cnt;
        t_total   submitted_cnt;
        int       peak_lvl;
        int       errors;
        int       pops_seen;

        function new();
            dropped_cnt   = '0;
            submitted_cnt = '0;
            peak_lvl      = 0;
            errors        = 0;
            pops_seen     = 0;
        endfunction

        function t_total bump(t_total v);
            return (v == '1) ? v : v + 1'b1;
        endfunction

        function t_lvl_out clip_level(int lvl);
            return (lvl > LVL_OUT_MAX) ? t_lvl_out'(LVL_OUT_MAX) : t_lvl_out'(lvl);
        endfunction

        function int level();
            return live_q.size();
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        // called once per accepted input transaction
        function void note_transaction(logic op, t_sample s);
            int       n;
            t_pop_rec r;
            if (op == OP_PUSH) begin
                submitted_cnt = bump(submitted_cnt);
                if (live_q.size() >= DEPTH) begin
                    // full: oldest goes, level stays at DEPTH
                    live_q.delete(0);
                    dropped_cnt = bump(dropped_cnt);
                end
                live_q.push_back(s);
                if (live_q.size() > peak_lvl)
                    peak_lvl = live_q.size();
            end else begin
                n = (live_q.size() < DRAIN_MAX) ? live_q.size() : DRAIN_MAX;
                for (int i = 0; i < n; i++) begin
                    r.smp       = live_q.pop_front();
                    r.last      = (i == n - 1);
                    r.fill      = clip_level(live_q.size());
                    r.dropped   = dropped_cnt;
                    r.submitted = submitted_cnt;
                    r.peak      = clip_level(peak_lvl);
                    owed_q.push_back(r);
                end
            end
        endfunction

        // called once per accepted output transaction
        function void check_pop(t_pop_rec got);
            t_pop_rec want;
            pops_seen++;
            if (owed_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("pop %0d unexpected: sample=%0d last=%0b fill=%0d",
                             pops_seen, got.smp, got.last, got.fill);
                return;
            end
            want = owed_q.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= 10) begin
                    $display("pop %0d exp: sample=%0d last=%0b fill=%0d drop=%0d sub=%0d hw=%0d",
                             pops_seen, want.smp, want.last, want.fill, want.dropped,
                             want.submitted, want.peak);
                    $display("pop %0d got: sample=%0d last=%0b fill=%0d drop=%0d sub=%0d hw=%0d",
                             pops_seen, got.smp, got.last, got.fill, got.dropped,
                             got.submitted, got.peak);
                end
            end
        endfunction
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    dosf_in_if  in_ch ();
    dosf_out_if out_ch ();

    fifo_scoreboard sb;

    drop_oldest_sample_fifo uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // present one transaction and hold it until accepted
    task automatic issue(logic op, t_sample s);
        in_ch.valid  <= 1'b1;
        in_ch.op     <= op;
        in_ch.sample <= s;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        sb.note_transaction(op, s);
    endtask

    task automatic go_quiet(int cycles);
        if (cycles > 0) begin
            in_ch.valid <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // sender holds off until every owed pop has come out
    task automatic wait_all_popped();
        in_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    function automatic t_sample pick_sample();
        case ($urandom_range(0, 9))
            0:       return 24'h7FFFFF;
            1:       return 24'h800000;
            2:       return '0;
            3:       return '1;
            default: return t_sample'($urandom);
        endcase
    endfunction

    task automatic random_phase(int count);
        int left;
        int burst;
        int drain_pct;
        left = count;
        while (left > 0) begin
            burst = $urandom_range(1, 40);
            case ($urandom_range(0, 3))
                0:       drain_pct = 2;
                1:       drain_pct = 8;
                2:       drain_pct = 20;
                default: drain_pct = 50;
            endcase
            for (int k = 0; k < burst && left > 0; k++) begin
                if ($urandom_range(0, 99) < drain_pct)
                    issue(OP_DRAIN, t_sample'($urandom));
                else
                    issue(OP_PUSH, pick_sample());
                left--;
            end
            if ($urandom_range(0, 3) != 0)
                go_quiet($urandom_range(1, 12));
        end
    endtask

    // output side: check, then pick next ready from the current stall mode
    initial begin
        t_pop_rec    got;
        int          cyc;
        int          mode;
        logic [15:0] mask;
        out_ch.ready = 1'b0;
        cyc  = 0;
        mode = 0;
        mask = 16'b1011_0111_1101_1001;
        forever begin
            @(posedge i_clk);
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
                got.smp       = out_ch.out_sample;
                got.last      = out_ch.last;
                got.fill      = out_ch.fill_level;
                got.dropped   = out_ch.dropped_total;
                got.submitted = out_ch.submitted_total;
                got.peak      = out_ch.high_water;
                sb.check_pop(got);
            end
            cyc++;
            if (cyc % 300 == 0)
                mode = $urandom_range(0, 2);
            mask = {mask[14:0], mask[15]};
            case (mode)
                0:       out_ch.ready <= 1'b1;
                1:       out_ch.ready <= mask[0];
                default: out_ch.ready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // watchdog: ends the run after a long stretch with no transaction
    initial begin
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
                (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
                idle = 0;
            else
                idle++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        in_ch.valid  = 1'b0;
        in_ch.op     = OP_PUSH;
        in_ch.sample = '0;
        sb = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: drain on empty, sample extremes, short burst, single pop
        issue(OP_DRAIN, 24'h123456);
        issue(OP_PUSH, 24'h7FFFFF);
        issue(OP_PUSH, 24'h800000);
        issue(OP_PUSH, 24'h000000);
        issue(OP_PUSH, 24'hFFFFFF);
        issue(OP_PUSH, 24'h555555);
        issue(OP_PUSH, 24'hAAAAAA);
        issue(OP_DRAIN, 24'h000000);
        issue(OP_DRAIN, 24'hFFFFFF);
        issue(OP_PUSH, 24'h000001);
        issue(OP_DRAIN, 24'hFFFFFF);
        wait_all_popped();

        // fill past one burst so a drain is cut at DRAIN_MAX
        for (int k = 0; k < DRAIN_MAX + BURST_EXTRA; k++) begin
            issue(OP_PUSH, pick_sample());
            if ($urandom_range(0, 15) == 0)
                go_quiet($urandom_range(1, 6));
        end
        // drain it in a full burst, then a partial one
        while (sb.level() > 0) begin
            issue(OP_DRAIN, t_sample'($urandom));
            if ($urandom_range(0, 3) == 0)
                go_quiet($urandom_range(1, 10));
        end
        issue(OP_DRAIN, t_sample'($urandom));
        wait_all_popped();

        random_phase(RANDOM_ITEMS / 2);
        wait_all_popped();
        random_phase(RANDOM_ITEMS - RANDOM_ITEMS / 2);
        // flush whatever is left in the queue
        while (sb.level() > 0)
            issue(OP_DRAIN, t_sample'($urandom));
        wait_all_popped();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> files.f
src/dosf_pkg.sv
src/dosf_in_if.sv
src/dosf_out_if.sv
src/dosf_front.sv
src/dosf_back.sv
src/drop_oldest_sample_fifo.sv
sim/tb.sv
